// ----- design/gfba_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfba_pkg: shared types and constants of the grouped free block allocator
// Sizes, request codes and memory port structs.
// ----------------------------------------------------------------------------
package gfba_pkg;

	localparam int NUM_BLOCKS = 1024;
	localparam int GROUP      = 16;        // power of two
	localparam int GROUPS     = NUM_BLOCKS / GROUP;

	localparam int BLK_W   = $clog2(NUM_BLOCKS + 1);   // block number / group index
	localparam int GRANT_W = BLK_W + 1;                // signed block number
	localparam int GROUP_W = $clog2(GROUP);            // stack address
	localparam int FILL_W  = $clog2(GROUP + 1);        // stack fill
	localparam int ENT_AW  = BLK_W + GROUP_W;          // group entry address
	localparam int ENT_D   = (NUM_BLOCKS + 1) * GROUP;
	localparam int META_D  = NUM_BLOCKS + 1;

	localparam int IN_W  = 16;
	localparam int OUT_W = 24;

	typedef enum logic [1:0] {
		MODE_ALLOC  = 2'd0,
		MODE_FREE   = 2'd1,
		MODE_FORMAT = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	// per group: written mark, link to next group, saved fill
	typedef struct packed {
		logic                      written;
		logic signed [GRANT_W-1:0] link;
		logic [FILL_W-1:0]         fill;
	} meta_t;

	typedef struct packed {
		logic               we;
		logic [GROUP_W-1:0] waddr;
		logic [BLK_W-1:0]   wdata;
		logic [GROUP_W-1:0] raddr;
	} stk_req_t;

	typedef struct packed {
		logic             meta_we;
		logic [BLK_W-1:0] meta_waddr;
		meta_t            meta_wdata;
		logic [BLK_W-1:0] meta_raddr;
		logic             ent_we;
		logic [ENT_AW-1:0] ent_waddr;
		logic [BLK_W-1:0] ent_wdata;
		logic [ENT_AW-1:0] ent_raddr;
	} store_req_t;

endpackage

// ----- design/gfba_stack.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfba_stack: in-core stack of free block numbers
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module gfba_stack (
	input  logic                      clk,
	input  gfba_pkg::stk_req_t        req,
	output logic [gfba_pkg::BLK_W-1:0] rdata
);
	import gfba_pkg::*;

	logic [BLK_W-1:0] mem [0:GROUP-1];
	logic [BLK_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata_q <= mem[req.raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- design/gfba_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfba_store: on-disk group store
// Per-group header memory (written mark, link, fill) and entry memory,
// each with one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module gfba_store (
	input  logic                       clk,
	input  gfba_pkg::store_req_t       req,
	output gfba_pkg::meta_t            meta_rd,
	output logic [gfba_pkg::BLK_W-1:0] ent_rd
);
	import gfba_pkg::*;

	meta_t            meta_mem [0:META_D-1];
	logic [BLK_W-1:0] ent_mem  [0:ENT_D-1];
	meta_t            meta_rd_q;
	logic [BLK_W-1:0] ent_rd_q;

	always_ff @(posedge clk) begin
		if (req.meta_we) begin
			meta_mem[req.meta_waddr] <= req.meta_wdata;
		end
		meta_rd_q <= meta_mem[req.meta_raddr];
	end

	always_ff @(posedge clk) begin
		if (req.ent_we) begin
			ent_mem[req.ent_waddr] <= req.ent_wdata;
		end
		ent_rd_q <= ent_mem[req.ent_raddr];
	end

	assign meta_rd = meta_rd_q;
	assign ent_rd  = ent_rd_q;

endmodule

// ----- design/grouped_free_block_allocator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grouped_free_block_allocator_core: grouped free list block allocator
// Keeps a stack of free blocks and a chain of saved groups in memory.
// ----------------------------------------------------------------------------
// Usage:
//  s_axis carries one request: mode (allocate, free, format) and block.
//  m_axis returns one result per request: granted, ok, free_left.
//  Steps from accept to result valid:
//   allocate            stack read; when the last stack entry is taken
//                       and the link is followed, the header and the
//                       entries of the next group are loaded as well
//   free                stack write; when the stack is full it is saved to its
//                       group (one entry a cycle through the stack RAM port)
//   format              header memory clear, one entry a cycle,
//                       then reload of group 1
//  Requests are taken one at a time; s_tready is high only while idle.
//  After reset all NUM_BLOCKS + 1 header entries are cleared and
//  group 1 is loaded before the first request is taken.
//  A result held by a stalled receiver stays in the output register; the
//  next request may be accepted meanwhile, its result waits for the slot.
// ----------------------------------------------------------------------------
module grouped_free_block_allocator_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [gfba_pkg::IN_W-1:0]   s_tdata,   // mode[1:0], block[12:2]
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [gfba_pkg::OUT_W-1:0]  m_tdata    // granted[11:0], ok[12], free_left[23:13]
);
	import gfba_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_AREAD = 9'b000000010,
		ST_CLR   = 9'b000000100,
		ST_LREQ  = 9'b000001000,
		ST_LMETA = 9'b000010000,
		ST_LCOPY = 9'b000100000,
		ST_SCOPY = 9'b001000000,
		ST_SFIN  = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;

	state_t                    state_q;
	logic [FILL_W-1:0]         fill_q;
	logic signed [GRANT_W-1:0] cur_q;
	logic signed [GRANT_W-1:0] nxt_q;
	logic [BLK_W-1:0]          total_q;
	logic [BLK_W-1:0]          ld_g_q;
	logic [BLK_W-1:0]          blk_q;
	logic [BLK_W-1:0]          clr_q;
	logic [FILL_W-1:0]         cnt_q;
	logic                      pend_s1;
	logic [GROUP_W-1:0]        idx_s1;
	logic                      wr_q;
	logic                      silent_q;
	logic signed [GRANT_W-1:0] grant_q;
	logic                      ok_q;

	logic                      out_valid_q;
	logic signed [GRANT_W-1:0] out_grant_q;
	logic                      out_ok_q;
	logic [BLK_W-1:0]          out_left_q;

	stk_req_t         stk_req;
	store_req_t       st_req;
	logic [BLK_W-1:0] stk_rd;
	meta_t            meta_rd;
	logic [BLK_W-1:0] ent_rd;

	mode_t            in_mode;
	logic [BLK_W-1:0] in_blk;
	logic             acc;
	logic [FILL_W-1:0] fill_m1;
	logic             cur_in;
	logic             nxt_in;
	logic             issue_l;
	logic             issue_s;
	logic [BLK_W-1:0] g_m1;
	logic             g_head;
	logic [BLK_W-1:0] g_idx;
	logic [FILL_W-1:0] meta_fill_c;
	logic [BLK_W-1:0] fmt_word;
	logic [GRANT_W-1:0] fmt_link;

	gfba_stack u_stack (
		.clk   (clk),
		.req   (stk_req),
		.rdata (stk_rd)
	);

	gfba_store u_store (
		.clk     (clk),
		.req     (st_req),
		.meta_rd (meta_rd),
		.ent_rd  (ent_rd)
	);

	assign in_mode  = mode_t'(s_tdata[1:0]);
	assign in_blk   = s_tdata[BLK_W+1:2];
	assign s_tready = (state_q == ST_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign fill_m1  = fill_q - 1'b1;
	assign cur_in   = !cur_q[GRANT_W-1] && (cur_q[BLK_W-1:0] <= BLK_W'(NUM_BLOCKS));
	assign nxt_in   = !nxt_q[GRANT_W-1] && (nxt_q[BLK_W-1:0] <= BLK_W'(NUM_BLOCKS));
	assign issue_l  = (cnt_q < fill_q);
	assign issue_s  = (cnt_q < FILL_W'(GROUP));

	// formatted layout of a never-written group
	assign g_m1     = ld_g_q - 1'b1;
	assign g_idx    = g_m1 >> GROUP_W;
	assign g_head   = (ld_g_q != '0) && (g_m1[GROUP_W-1:0] == '0)
		&& (g_idx < BLK_W'(GROUPS));
	assign fmt_link = (g_idx + 1'b1 == BLK_W'(GROUPS)) ? '1
		: ({1'b0, ld_g_q} + GRANT_W'(GROUP));
	assign fmt_word = ld_g_q + BLK_W'(cnt_q);
	assign meta_fill_c = (meta_rd.fill > FILL_W'(GROUP)) ? FILL_W'(GROUP) : meta_rd.fill;

	always_comb begin
		stk_req = '0;
		st_req  = '0;
		unique case (state_q)
			ST_IDLE: begin
				stk_req.raddr = fill_m1[GROUP_W-1:0];
				if (acc && in_mode == MODE_FREE) begin
					if (fill_q < FILL_W'(GROUP)) begin
						stk_req.we    = 1'b1;
						stk_req.waddr = fill_q[GROUP_W-1:0];
						stk_req.wdata = in_blk;
					end else if (cur_in) begin
						st_req.meta_we    = 1'b1;
						st_req.meta_waddr = cur_q[BLK_W-1:0];
						st_req.meta_wdata = '{written: 1'b1, link: nxt_q, fill: fill_q};
					end
				end
			end
			ST_CLR: begin
				st_req.meta_we    = 1'b1;
				st_req.meta_waddr = clr_q;
			end
			ST_LREQ: begin
				st_req.meta_raddr = ld_g_q;
			end
			ST_LCOPY: begin
				st_req.ent_raddr = {ld_g_q, cnt_q[GROUP_W-1:0]};
				if (wr_q) begin
					stk_req.we    = pend_s1;
					stk_req.waddr = idx_s1;
					stk_req.wdata = ent_rd;
				end else begin
					stk_req.we    = issue_l;
					stk_req.waddr = cnt_q[GROUP_W-1:0];
					stk_req.wdata = fmt_word;
				end
			end
			ST_SCOPY: begin
				stk_req.raddr    = cnt_q[GROUP_W-1:0];
				st_req.ent_we    = pend_s1;
				st_req.ent_waddr = {cur_q[BLK_W-1:0], idx_s1};
				st_req.ent_wdata = stk_rd;
			end
			ST_SFIN: begin
				stk_req.we    = 1'b1;
				stk_req.wdata = blk_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLR;
			fill_q   <= '0;
			cur_q    <= GRANT_W'(1);
			nxt_q    <= '1;
			total_q  <= BLK_W'(NUM_BLOCKS - 1);
			ld_g_q   <= BLK_W'(1);
			blk_q    <= '0;
			clr_q    <= '0;
			cnt_q    <= '0;
			pend_s1  <= 1'b0;
			idx_s1   <= '0;
			wr_q     <= 1'b0;
			silent_q <= 1'b1;
			grant_q  <= '1;
			ok_q     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						silent_q <= 1'b0;
						grant_q  <= '1;
						unique case (in_mode)
							MODE_ALLOC: begin
								if (total_q != '0 && fill_q != '0) begin
									fill_q  <= fill_m1;
									total_q <= total_q - 1'b1;
									ok_q    <= 1'b1;
									state_q <= ST_AREAD;
								end else begin
									ok_q    <= 1'b0;
									state_q <= ST_DONE;
								end
							end
							MODE_FREE: begin
								ok_q <= 1'b1;
								if (total_q < BLK_W'(NUM_BLOCKS)) begin
									total_q <= total_q + 1'b1;
								end
								if (fill_q < FILL_W'(GROUP)) begin
									fill_q  <= fill_q + 1'b1;
									state_q <= ST_DONE;
								end else begin
									blk_q   <= in_blk;
									cnt_q   <= '0;
									pend_s1 <= 1'b0;
									state_q <= cur_in ? ST_SCOPY : ST_SFIN;
								end
							end
							MODE_FORMAT: begin
								ok_q    <= 1'b1;
								clr_q   <= '0;
								state_q <= ST_CLR;
							end
							default: begin
								ok_q    <= 1'b0;
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_AREAD: begin
					grant_q <= {1'b0, stk_rd};
					if (fill_q == '0) begin
						cur_q <= nxt_q;
						if (nxt_in) begin
							ld_g_q  <= nxt_q[BLK_W-1:0];
							state_q <= ST_LREQ;
						end else begin
							state_q <= ST_DONE;
						end
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BLK_W'(NUM_BLOCKS)) begin
						cur_q   <= GRANT_W'(1);
						total_q <= BLK_W'(NUM_BLOCKS - 1);
						ld_g_q  <= BLK_W'(1);
						state_q <= ST_LREQ;
					end
				end
				ST_LREQ: begin
					state_q <= ST_LMETA;
				end
				ST_LMETA: begin
					cnt_q   <= '0;
					pend_s1 <= 1'b0;
					if (meta_rd.written) begin
						nxt_q   <= meta_rd.link;
						fill_q  <= meta_fill_c;
						wr_q    <= 1'b1;
						state_q <= ST_LCOPY;
					end else if (g_head) begin
						nxt_q   <= fmt_link;
						fill_q  <= FILL_W'(GROUP);
						wr_q    <= 1'b0;
						state_q <= ST_LCOPY;
					end else begin
						nxt_q   <= '1;
						fill_q  <= '0;
						state_q <= silent_q ? ST_IDLE : ST_DONE;
					end
				end
				ST_LCOPY: begin
					if (issue_l) begin
						cnt_q <= cnt_q + 1'b1;
					end
					pend_s1 <= issue_l && wr_q;
					idx_s1  <= cnt_q[GROUP_W-1:0];
					if (!issue_l && !pend_s1) begin
						state_q <= silent_q ? ST_IDLE : ST_DONE;
					end
				end
				ST_SCOPY: begin
					if (issue_s) begin
						cnt_q <= cnt_q + 1'b1;
					end
					pend_s1 <= issue_s;
					idx_s1  <= cnt_q[GROUP_W-1:0];
					if (!issue_s && !pend_s1) begin
						state_q <= ST_SFIN;
					end
				end
				ST_SFIN: begin
					fill_q  <= FILL_W'(1);
					nxt_q   <= cur_q;
					cur_q   <= {1'b0, blk_q};
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register: loaded from DONE when the slot is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && (!out_valid_q || m_tready)) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!out_valid_q || m_tready)) begin
			out_grant_q <= grant_q;
			out_ok_q    <= ok_q;
			out_left_q  <= total_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_left_q, out_ok_q, out_grant_q};

endmodule
